[src/asm_pkg.sv]
// Shared types, constants and helpers for the alarm slot manager.
package asm_pkg;

  // Table geometry.
  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Most results that one tick may give.
  localparam int MAX_FIRED  = 8;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRED + 1);

  // Field widths of the beats.
  localparam int TIME_W  = 32;
  localparam int WORD_W  = 32;
  localparam int EVENT_W = 8;
  localparam int DELAY_W = 23;
  localparam int SLOT_W  = 3;

  // Positions inside the packed alarm word.
  localparam int EVENT_LSB = 24;
  localparam int PER_BIT   = 23;

  // Item function codes.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new input beat and restart the scan
    logic step;   // process the slot at the scan index and advance
    logic flush;  // push the held result as the last of this tick
    logic place;  // write a new alarm into the free slot found
  } asm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_set;     // current item is a set
    logic hit;        // slot at the scan index matches or is due
    logic idx_last;   // scan index is at the final slot
    logic pend_valid; // a fired result is held back
    logic out_free;   // output register can take a beat this cycle
  } asm_sts_t;

  // Saturating add of a time and a delay.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

[src/asm_chan_if.sv]
// Channel interfaces for the input items and the fired results.

interface asm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [asm_pkg::TIME_W-1:0]   now_ms;
  logic [asm_pkg::WORD_W-1:0]   alarm_word;

  modport source (output valid, output func, output now_ms, output alarm_word,
                  input ready);
  modport sink   (input valid, input func, input now_ms, input alarm_word,
                  output ready);
endinterface

interface asm_out_if;
  logic                         valid;
  logic                         ready;
  logic [asm_pkg::EVENT_W-1:0]  fired_event;
  logic [asm_pkg::SLOT_W-1:0]   fired_slot;
  logic                         last_fired;

  modport source (output valid, output fired_event, output fired_slot,
                  output last_fired, input ready);
  modport sink   (input valid, input fired_event, input fired_slot,
                  input last_fired, output ready);
endinterface

[src/asm_ctrl.sv]
// Controller state machine that sequences the slot scan for each item.
module asm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  asm_pkg::asm_sts_t sts,
  output asm_pkg::asm_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   scan_stall;

  // A due slot cannot be taken while a held result waits on a full output.
  assign scan_stall = !sts.is_set && sts.hit && sts.pend_valid && !sts.out_free;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_stall) begin
          cmd.step = 1'b1;
          if (sts.idx_last) begin
            state_nxt = sts.is_set ? S_PLACE : S_FLUSH;
          end
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/asm_dpath.sv]
// Datapath: slot table, scan index, held result and output register.
module asm_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  asm_pkg::asm_cmd_t             cmd,
  output asm_pkg::asm_sts_t             sts,
  input  logic                          in_func,
  input  logic [asm_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [asm_pkg::WORD_W-1:0]    in_alarm_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [asm_pkg::EVENT_W-1:0]   out_fired_event,
  output logic [asm_pkg::SLOT_W-1:0]    out_fired_slot,
  output logic                          out_last_fired
);

  localparam int SLOTS      = asm_pkg::SLOTS;
  localparam int IDX_W      = asm_pkg::IDX_W;
  localparam int TIME_W     = asm_pkg::TIME_W;
  localparam int EVENT_W    = asm_pkg::EVENT_W;
  localparam int DELAY_W    = asm_pkg::DELAY_W;
  localparam int SLOT_W     = asm_pkg::SLOT_W;
  localparam int MAX_FIRED  = asm_pkg::MAX_FIRED;
  localparam int FIRE_CNT_W = asm_pkg::FIRE_CNT_W;

  // Slot table.
  logic                valid_r    [SLOTS];
  logic [EVENT_W-1:0]  event_r    [SLOTS];
  logic                per_r      [SLOTS];
  logic [DELAY_W-1:0]  period_r   [SLOTS];
  logic [TIME_W-1:0]   deadline_r [SLOTS];

  // Captured item.
  logic                func_r;
  logic [TIME_W-1:0]   now_r;
  logic [EVENT_W-1:0]  id_r;
  logic                new_per_r;
  logic [DELAY_W-1:0]  delay_r;

  // Scan bookkeeping.
  logic [IDX_W-1:0]      idx_r;
  logic                  matched_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic [FIRE_CNT_W-1:0] fire_cnt_r;

  // Result held until the next one shows whether it is the last.
  logic                pend_valid_r;
  logic [EVENT_W-1:0]  pend_event_r;
  logic [SLOT_W-1:0]   pend_slot_r;

  // Output register.
  logic                out_valid_r;
  logic [EVENT_W-1:0]  out_event_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_last_r;

  logic                cur_valid;
  logic                id_match;
  logic                due;
  logic                room;
  logic                hit;
  logic                is_set;
  logic                tick_fire;
  logic                set_hit;
  logic                take_free;
  logic                do_place;
  logic                push;
  logic                push_last;
  logic                out_free;
  logic [TIME_W-1:0]   rearm;

  // Look at the slot under the scan index.
  assign is_set    = (func_r == asm_pkg::FUNC_SET);
  assign cur_valid = valid_r[idx_r];
  assign id_match  = (event_r[idx_r] == id_r) && per_r[idx_r];
  assign due       = (now_r >= deadline_r[idx_r]);
  // Once a tick has given its most results, further due slots wait.
  assign room      = (fire_cnt_r != FIRE_CNT_W'(MAX_FIRED));
  assign hit       = cur_valid && (is_set ? id_match : (due && room));
  assign rearm     = asm_pkg::sat_add(now_r, TIME_W'(period_r[idx_r]));

  assign tick_fire = cmd.step && !is_set && hit;
  assign set_hit   = cmd.step && is_set && hit;
  assign take_free = cmd.step && is_set && !cur_valid && !free_found_r;
  assign do_place  = cmd.place && !matched_r && free_found_r;

  // A new firing releases the held one; the flush releases it as last.
  assign out_free  = !out_valid_r || out_ready;
  assign push      = (tick_fire && pend_valid_r) || (cmd.flush && pend_valid_r);
  assign push_last = cmd.flush;

  assign sts.is_set     = is_set;
  assign sts.hit        = hit;
  assign sts.idx_last   = (idx_r == IDX_W'(SLOTS - 1));
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  // Valid bits and control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      matched_r    <= 1'b0;
      free_found_r <= 1'b0;
      fire_cnt_r   <= '0;
      idx_r        <= '0;
    end else begin
      if (cmd.load) begin
        idx_r        <= '0;
        matched_r    <= 1'b0;
        free_found_r <= 1'b0;
        fire_cnt_r   <= '0;
      end
      if (cmd.step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (tick_fire) begin
        pend_valid_r <= 1'b1;
        fire_cnt_r   <= fire_cnt_r + 1'b1;
        if (!per_r[idx_r]) begin
          valid_r[idx_r] <= 1'b0;
        end
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (set_hit) begin
        matched_r <= 1'b1;
        if (delay_r == '0) begin
          valid_r[idx_r] <= 1'b0;
        end
      end
      if (take_free) begin
        free_found_r <= 1'b1;
      end
      if (do_place) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot payload, item capture and result data.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_func;
      now_r     <= in_now_ms;
      id_r      <= in_alarm_word[asm_pkg::EVENT_LSB +: EVENT_W];
      new_per_r <= in_alarm_word[asm_pkg::PER_BIT];
      delay_r   <= in_alarm_word[DELAY_W-1:0];
    end
    if (take_free) begin
      free_idx_r <= idx_r;
    end
    if (tick_fire) begin
      pend_event_r <= event_r[idx_r];
      pend_slot_r  <= SLOT_W'(idx_r);
      if (per_r[idx_r]) begin
        deadline_r[idx_r] <= rearm;
      end
    end
    if (set_hit && (delay_r != '0)) begin
      period_r[idx_r] <= delay_r;
    end
    if (do_place) begin
      event_r[free_idx_r]    <= id_r;
      per_r[free_idx_r]      <= new_per_r;
      period_r[free_idx_r]   <= delay_r;
      deadline_r[free_idx_r] <= asm_pkg::sat_add(now_r, TIME_W'(delay_r));
    end
    if (push) begin
      out_event_r <= pend_event_r;
      out_slot_r  <= pend_slot_r;
      out_last_r  <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fired_event = out_event_r;
  assign out_fired_slot  = out_slot_r;
  assign out_last_fired  = out_last_r;

endmodule

[src/alarm_slot_manager_unit.sv]
// Top level of the alarm slot manager: controller plus datapath.
//
// Input channel in_bus carries one item per beat: func selects a tick
// (check alarms) or a set (create or update an alarm); now_ms is the time
// and alarm_word packs the event id, periodic bit and delay of a set.
// Result channel out_bus carries one beat per fired slot of a tick, with
// fired_event, fired_slot and last_fired high on the last beat of the tick.
// A set and a tick with no due slot give no beats.
// The next item is accepted only after the current one is through: a load,
// a scan that takes one slot at a time through the single scan index, and
// a wrap-up that places a set or flushes a tick.
// A fired result is held back until the next firing slot or the end of the
// scan shows whether it is the last; the first beat of a tick is valid in the
// cycle after the scan takes its second firing slot, or, when only one fires,
// once the wrap-up flushes it after the scan reaches the last slot.
// When the receiver stalls, the scan pauses at the next firing slot and
// resumes as soon as the output register drains.
// Synchronous active-low reset empties the table and drops any held result;
// no clearing pass is needed.
module alarm_slot_manager_unit (
  input  logic      clk,
  input  logic      rst_n,
  asm_in_if.sink    in_bus,
  asm_out_if.source out_bus
);

  asm_pkg::asm_cmd_t cmd;
  asm_pkg::asm_sts_t sts;

  // Sequencing.
  asm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot table and result path.
  asm_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_bus.func),
    .in_now_ms       (in_bus.now_ms),
    .in_alarm_word   (in_bus.alarm_word),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_fired_event (out_bus.fired_event),
    .out_fired_slot  (out_bus.fired_slot),
    .out_last_fired  (out_bus.last_fired)
  );

endmodule

[verif/tb_alarm_slot_manager_unit.sv]
// Testbench for alarm_slot_manager_unit: directed table, pressure burst and random traffic.
`timescale 1ns / 1ps

module tb_alarm_slot_manager_unit;

  localparam int   SLOTS     = asm_pkg::SLOTS;
  localparam int   TIME_W    = asm_pkg::TIME_W;
  localparam int   WORD_W    = asm_pkg::WORD_W;
  localparam int   EVENT_W   = asm_pkg::EVENT_W;
  localparam int   DELAY_W   = asm_pkg::DELAY_W;
  localparam int   SLOT_W    = asm_pkg::SLOT_W;
  localparam int   EVENT_LSB = asm_pkg::EVENT_LSB;
  localparam int   PER_BIT   = asm_pkg::PER_BIT;
  localparam logic FUNC_TICK = asm_pkg::FUNC_TICK;
  localparam logic FUNC_SET  = asm_pkg::FUNC_SET;

  localparam int MAX_FIRED    = asm_pkg::MAX_FIRED;
  localparam int STALL_CYCLES = 200;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_ms;
    logic [WORD_W-1:0] alarm_word;
  } alarm_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } fired_beat_t;

  // One row of the directed table; typed rows carry their expectation inline.
  typedef struct packed {
    alarm_item_t item;
    logic        typed;
    logic        typed_fires;
    fired_beat_t beat;
  } stim_row_t;

  logic clk;
  logic rst_n;

  asm_in_if  in_ch ();
  asm_out_if out_ch ();

  alarm_slot_manager_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  // Shadow copy of the alarm table.
  logic               tbl_valid    [SLOTS];
  logic [EVENT_W-1:0] tbl_event    [SLOTS];
  logic               tbl_periodic [SLOTS];
  logic [DELAY_W-1:0] tbl_period   [SLOTS];
  logic [TIME_W-1:0]  tbl_deadline [SLOTS];

  fired_beat_t tick_beats[$];
  fired_beat_t fired_q[$];
  stim_row_t   directed_rows[$];

  int unsigned fail_count    = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_idle_pct  = 0;
  bit          stall_request = 1'b0;
  logic [TIME_W-1:0] sim_ms;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  // Deadline arithmetic: the sum is held at the top of the time range.
  function automatic logic [TIME_W-1:0] clamp_sum(input logic [TIME_W-1:0] t,
                                                  input logic [DELAY_W-1:0] d);
    logic [TIME_W:0] s;
    s = (TIME_W+1)'(t) + (TIME_W+1)'(d);
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] pack_alarm(input logic [EVENT_W-1:0] id,
                                                   input logic per,
                                                   input logic [DELAY_W-1:0] dly);
    return {id, per, dly};
  endfunction

  // Applies one item to the shadow table and collects the beats a tick fires.
  function automatic void advance_table(input alarm_item_t it);
    logic [EVENT_W-1:0] id;
    logic               per;
    logic [DELAY_W-1:0] dly;
    bit                 matched;
    bit                 placed;
    bit                 held;
    fired_beat_t        pend;
    int                 n;
    tick_beats.delete();
    id  = it.alarm_word[EVENT_LSB +: EVENT_W];
    per = it.alarm_word[PER_BIT];
    dly = it.alarm_word[DELAY_W-1:0];
    if (it.func == FUNC_SET) begin
      // Periodic slots with the same id take the update; otherwise allocate.
      matched = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i] && tbl_event[i] == id && tbl_periodic[i]) begin
          if (dly == '0) tbl_valid[i] = 1'b0;
          else tbl_period[i] = dly;
          matched = 1'b1;
        end
      end
      placed = matched;
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !tbl_valid[i]) begin
          tbl_valid[i]    = 1'b1;
          tbl_event[i]    = id;
          tbl_periodic[i] = per;
          tbl_period[i]   = dly;
          tbl_deadline[i] = clamp_sum(it.now_ms, dly);
          placed          = 1'b1;
        end
      end
    end else begin
      // Each beat is held until the next one shows it was not the last.
      held = 1'b0;
      n    = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (n < MAX_FIRED && tbl_valid[i] && it.now_ms >= tbl_deadline[i]) begin
          if (held) tick_beats.push_back(pend);
          pend.ev   = tbl_event[i];
          pend.slot = SLOT_W'(i);
          pend.last = 1'b0;
          held      = 1'b1;
          n++;
          if (tbl_periodic[i]) tbl_deadline[i] = clamp_sum(it.now_ms, tbl_period[i]);
          else tbl_valid[i] = 1'b0;
        end
      end
      if (held) begin
        pend.last = 1'b1;
        tick_beats.push_back(pend);
      end
    end
  endfunction

  // Offers one item, waits for its beat, then updates the shadow table.
  task automatic accept_item(input alarm_item_t it, input bit use_predicted);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= it.func;
    in_ch.now_ms     <= it.now_ms;
    in_ch.alarm_word <= it.alarm_word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_table(it);
    if (use_predicted) begin
      foreach (tick_beats[k]) fired_q.push_back(tick_beats[k]);
    end
  endtask

  task automatic add_row(input logic func, input logic [TIME_W-1:0] now,
                         input logic [WORD_W-1:0] word, input logic typed,
                         input logic fires, input logic [EVENT_W-1:0] ev,
                         input logic [SLOT_W-1:0] slot);
    stim_row_t r;
    r.item.func       = func;
    r.item.now_ms     = now;
    r.item.alarm_word = word;
    r.typed           = typed;
    r.typed_fires     = fires;
    r.beat.ev         = ev;
    r.beat.slot       = slot;
    r.beat.last       = 1'b1;
    directed_rows.push_back(r);
  endtask

  // Random traffic: mostly a steadily advancing clock with a small id pool,
  // with some full-range times and delays mixed in.
  function automatic alarm_item_t random_item();
    alarm_item_t        it;
    int unsigned        r;
    logic [EVENT_W-1:0] id;
    logic [DELAY_W-1:0] dly;
    r = $urandom_range(99);
    if (r < 8) begin
      it.now_ms = $urandom();
    end else if (r < 11) begin
      it.now_ms = {TIME_W{1'b1}} - $urandom_range(50);
    end else begin
      sim_ms    = sim_ms + $urandom_range(30);
      it.now_ms = sim_ms;
    end
    if ($urandom_range(99) < 55) begin
      it.func       = FUNC_TICK;
      it.alarm_word = $urandom();
    end else begin
      it.func = FUNC_SET;
      id      = ($urandom_range(99) < 75) ? EVENT_W'($urandom_range(5)) : EVENT_W'($urandom());
      r       = $urandom_range(99);
      if (r < 10) dly = '0;
      else if (r < 85) dly = DELAY_W'($urandom_range(60, 1));
      else dly = DELAY_W'($urandom());
      it.alarm_word = pack_alarm(id, 1'($urandom_range(1)), dly);
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned in_pct,
                            input int unsigned out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (count) accept_item(random_item(), 1'b1);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned held_cycles;
    bit          stall_done;
    stall_done   = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !stall_done) begin
        stall_done   = 1'b1;
        out_ch.ready <= 1'b0;
        for (held_cycles = 0; held_cycles < STALL_CYCLES; held_cycles++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Checks each result beat against the oldest expectation.
  always @(posedge clk) begin : check_fired
    fired_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fired_q.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual event %0h slot %0d last %0b",
                 $time, out_ch.fired_event, out_ch.fired_slot, out_ch.last_fired);
        fail_count++;
      end else begin
        want = fired_q.pop_front();
        if (out_ch.fired_event !== want.ev) begin
          $display("%0t ns: fired_event expected %0h, actual %0h",
                   $time, want.ev, out_ch.fired_event);
          fail_count++;
        end
        if (out_ch.fired_slot !== want.slot) begin
          $display("%0t ns: fired_slot expected %0d, actual %0d",
                   $time, want.slot, out_ch.fired_slot);
          fail_count++;
        end
        if (out_ch.last_fired !== want.last) begin
          $display("%0t ns: last_fired expected %0b, actual %0b",
                   $time, want.last, out_ch.last_fired);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    alarm_item_t it;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_TICK;
    in_ch.now_ms     <= '0;
    in_ch.alarm_word <= '0;
    rst_n            <= 1'b0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;

    // Directed table: empty table, saturation, zero delay, updates, full table.
    add_row(FUNC_TICK, 32'd0, '0, 1'b1, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'hFFFF_FFFF, pack_alarm(8'hFF, 1'b0, 23'h7F_FFFF), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'd100, pack_alarm(8'h00, 1'b1, 23'd0), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_TICK, 32'd99, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0);
    add_row(FUNC_TICK, 32'd100, '0, 1'b1, 1'b1, 8'h00, 3'd1);
    add_row(FUNC_TICK, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'd200, pack_alarm(8'h00, 1'b1, 23'd0), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'd1000, pack_alarm(8'h5A, 1'b0, 23'd10), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'd1000, pack_alarm(8'h5A, 1'b0, 23'd20), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'd1000, pack_alarm(8'h33, 1'b1, 23'd5), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'd1000, pack_alarm(8'h33, 1'b0, 23'd50), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_TICK, 32'd1005, '0, 1'b1, 1'b1, 8'h33, 3'd2);
    add_row(FUNC_TICK, 32'd1020, '0, 1'b0, 1'b0, '0, '0);
    for (int k = 0; k < 7; k++) begin
      add_row(FUNC_SET, 32'd2000, pack_alarm(EVENT_W'(8'h81 + k), 1'b0, 23'd1), 1'b1, 1'b0,
              '0, '0);
    end
    // The table is full here, so this alarm is dropped.
    add_row(FUNC_SET, 32'd2000, pack_alarm(8'h99, 1'b1, 23'd1), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_TICK, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0, '0);
    add_row(FUNC_TICK, 32'd0, '0, 1'b1, 1'b0, '0, '0);
    add_row(FUNC_SET, 32'd0, pack_alarm(8'h33, 1'b1, 23'd0), 1'b1, 1'b0, '0, '0);
    add_row(FUNC_TICK, 32'hFFFF_FFFF, '0, 1'b1, 1'b0, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      accept_item(directed_rows[r].item, !directed_rows[r].typed);
      if (directed_rows[r].typed && directed_rows[r].typed_fires)
        fired_q.push_back(directed_rows[r].beat);
    end

    // Pressure: eight periodic alarms fire on every tick while the receiver holds off.
    for (int k = 0; k < SLOTS; k++) begin
      it.func       = FUNC_SET;
      it.now_ms     = 32'd3000;
      it.alarm_word = pack_alarm(EVENT_W'(8'hC0 + k), 1'b1, 23'd1);
      accept_item(it, 1'b1);
    end
    stall_request <= 1'b1;
    for (int k = 1; k <= 6; k++) begin
      it.func       = FUNC_TICK;
      it.now_ms     = 32'd3000 + k;
      it.alarm_word = $urandom();
      accept_item(it, 1'b1);
    end
    for (int k = 0; k < SLOTS; k++) begin
      it.func       = FUNC_SET;
      it.now_ms     = 32'd3100;
      it.alarm_word = pack_alarm(EVENT_W'(8'hC0 + k), 1'b0, 23'd0);
      accept_item(it, 1'b1);
    end

    // Random traffic under three idling patterns.
    sim_ms = 32'd5000;
    run_random(70, 17, 64);
    run_random(70, 64, 17);
    run_random(65, 0, 0);

    // Drain and let any trailing scan finish.
    in_ch.valid <= 1'b0;
    while (fired_q.size() != 0) @(posedge clk);
    repeat (4 * (SLOTS + 2)) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
